@@ hw/rtl/block_list_encoder_macros.svh @@
// Assertion macros shared by the block list encoder.
`ifndef BLOCK_LIST_ENCODER_MACROS_SVH
`define BLOCK_LIST_ENCODER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ble_pkg.sv @@
package ble_pkg;

	localparam int CODE_W   = 16;
	localparam int MODE_W   = 3;
	localparam int BLOCK_W  = 16;
	localparam int BYTE_W   = 8;
	localparam int SLOT_W   = 4;
	localparam int COUNT_W  = 5;
	localparam int LENGTH_W = 9;
	localparam int ERR_W    = 2;

	// Block list length at which further requests are refused.
	localparam int MaxListBytes = 255;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE       = 2'd0,
		ERR_TABLE_FULL = 2'd1,
		ERR_LIST_FULL  = 2'd2
	} err_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic                item_last;
		logic [SLOT_W-1:0]   slot;
		logic                service_new;
		logic [COUNT_W-1:0]  service_count;
		logic [LENGTH_W-1:0] list_length;
		err_t                error;
	} result_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} tbl_ctrl_t;

endpackage

@@ hw/rtl/ble_req_if.sv @@
interface ble_req_if;
	logic                         valid;
	logic                         ready;
	logic                         start_list;
	logic [ble_pkg::CODE_W-1:0]   service_code;
	logic [ble_pkg::MODE_W-1:0]   access_mode;
	logic [ble_pkg::BLOCK_W-1:0]  block_number;

	modport source (
		output valid, start_list, service_code, access_mode, block_number,
		input  ready
	);
	modport sink (
		input  valid, start_list, service_code, access_mode, block_number,
		output ready
	);
endinterface

@@ hw/rtl/ble_res_if.sv @@
interface ble_res_if;
	logic                          valid;
	logic                          ready;
	logic [ble_pkg::BYTE_W-1:0]    out_byte;
	logic                          item_last;
	logic [ble_pkg::SLOT_W-1:0]    slot;
	logic                          service_new;
	logic [ble_pkg::COUNT_W-1:0]   service_count;
	logic [ble_pkg::LENGTH_W-1:0]  list_length;
	logic [ble_pkg::ERR_W-1:0]     error;

	modport source (
		output valid, out_byte, item_last, slot, service_new, service_count,
		       list_length, error,
		input  ready
	);
	modport sink (
		input  valid, out_byte, item_last, slot, service_new, service_count,
		       list_length, error,
		output ready
	);
endinterface

@@ hw/rtl/block_list_encoder.sv @@
// Channel | Dir | Role                    | Request accepted when
// req     | in  | block request           | req.valid && req.ready
// res     | out | one block list byte     | res.valid && res.ready
//
// A request passes through these steps when the output side is free: it is accepted,
// then each service table slot is compared in turn (up to the services held) in a read
// and a compare step, a new service is added or a full table is found (skipped on a hit
// or a full list), and the result bytes are emitted one after another (n is 1, 2 or 3).
// The table search reads one slot per read and compare pass of the shared comparator.
// Reset clears the service count, the list length and the output register.
// A stalled result holds the emitter; the next request is taken once the last byte of
// the current one sits in the output register.
module block_list_encoder #(
	parameter int MAX_SERVICES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	ble_req_if.sink   req,
	ble_res_if.source res
);

	localparam int IDX_W = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_ADD,
		S_EMIT
	} state_t;

	state_t                             state_q;
	logic [ble_pkg::COUNT_W-1:0]        svc_total_q;
	logic [ble_pkg::LENGTH_W-1:0]       bytes_total_q;
	logic [IDX_W-1:0]                   idx_q;
	logic [ble_pkg::CODE_W-1:0]         code_q;
	logic [ble_pkg::MODE_W-1:0]         mode_q;
	logic [ble_pkg::BLOCK_W-1:0]        block_q;
	logic [ble_pkg::SLOT_W-1:0]         slot_q;
	logic                               fresh_q;
	ble_pkg::err_t                      err_q;
	logic [1:0]                         byte_idx_q;
	logic                               res_valid_q;
	ble_pkg::result_t                   res_q;

	ble_pkg::tbl_ctrl_t                 tbl_ctrl;
	logic                               hit;
	logic [ble_pkg::COUNT_W-1:0]        tot_eff;
	logic [ble_pkg::LENGTH_W-1:0]       len_eff;
	logic                               out_free;
	logic                               short_elem;
	logic                               last_byte;
	logic [ble_pkg::BYTE_W-1:0]         cur_byte;

	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !res_valid_q || res.ready;

	assign tot_eff = req.start_list ? '0 : svc_total_q;
	assign len_eff = req.start_list ? '0 : bytes_total_q;

	assign tbl_ctrl.rd_en = (state_q == S_READ);
	assign tbl_ctrl.wr_en = (state_q == S_ADD) && (svc_total_q < ble_pkg::COUNT_W'(MAX_SERVICES));

	ble_svc_table #(
		.DEPTH(MAX_SERVICES),
		.IDX_W(IDX_W)
	) u_svc_table (
		.clk    (clk),
		.ctrl   (tbl_ctrl),
		.wr_addr(svc_total_q[IDX_W-1:0]),
		.wr_data(code_q),
		.rd_addr(idx_q),
		.key    (code_q),
		.hit    (hit)
	);

	// A block number that fits in a byte gives the short two-byte element.
	assign short_elem = (block_q[15:8] == 8'd0);
	assign last_byte  = short_elem ? (byte_idx_q == 2'd1) : (byte_idx_q == 2'd2);

	always_comb begin
		case (byte_idx_q)
			2'd0:    cur_byte = {short_elem, mode_q, slot_q};
			2'd1:    cur_byte = block_q[7:0];
			2'd2:    cur_byte = block_q[15:8];
			default: cur_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			svc_total_q   <= '0;
			bytes_total_q <= '0;
			idx_q         <= '0;
			code_q        <= '0;
			mode_q        <= '0;
			block_q       <= '0;
			slot_q        <= '0;
			fresh_q       <= 1'b0;
			err_q         <= ble_pkg::ERR_NONE;
			byte_idx_q    <= '0;
			res_valid_q   <= 1'b0;
			res_q         <= '0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						code_q        <= req.service_code;
						mode_q        <= req.access_mode;
						block_q       <= req.block_number;
						svc_total_q   <= tot_eff;
						bytes_total_q <= len_eff;
						idx_q         <= '0;
						byte_idx_q    <= '0;
						if (len_eff >= ble_pkg::LENGTH_W'(ble_pkg::MaxListBytes)) begin
							err_q   <= ble_pkg::ERR_LIST_FULL;
							state_q <= S_EMIT;
						end else begin
							err_q   <= ble_pkg::ERR_NONE;
							state_q <= (tot_eff == '0) ? S_ADD : S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						slot_q  <= ble_pkg::SLOT_W'(idx_q);
						fresh_q <= 1'b0;
						state_q <= S_EMIT;
					end else if (ble_pkg::COUNT_W'(idx_q) + 1'b1 == svc_total_q) begin
						state_q <= S_ADD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_ADD: begin
					if (svc_total_q >= ble_pkg::COUNT_W'(MAX_SERVICES)) begin
						err_q <= ble_pkg::ERR_TABLE_FULL;
					end else begin
						slot_q      <= ble_pkg::SLOT_W'(svc_total_q);
						fresh_q     <= 1'b1;
						svc_total_q <= svc_total_q + 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						res_valid_q         <= 1'b1;
						res_q.service_count <= svc_total_q;
						res_q.error         <= err_q;
						if (err_q != ble_pkg::ERR_NONE) begin
							res_q.out_byte    <= '0;
							res_q.item_last   <= 1'b1;
							res_q.slot        <= '0;
							res_q.service_new <= 1'b0;
							res_q.list_length <= bytes_total_q;
							state_q           <= S_IDLE;
						end else begin
							res_q.out_byte    <= cur_byte;
							res_q.item_last   <= last_byte;
							res_q.slot        <= slot_q;
							res_q.service_new <= fresh_q;
							res_q.list_length <= bytes_total_q + 1'b1;
							bytes_total_q     <= bytes_total_q + 1'b1;
							byte_idx_q        <= byte_idx_q + 1'b1;
							if (last_byte) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid         = res_valid_q;
	assign res.out_byte      = res_q.out_byte;
	assign res.item_last     = res_q.item_last;
	assign res.slot          = res_q.slot;
	assign res.service_new   = res_q.service_new;
	assign res.service_count = res_q.service_count;
	assign res.list_length   = res_q.list_length;
	assign res.error         = res_q.error;

`include "block_list_encoder_macros.svh"

	`BLE_ASSERT_NOW(a_svc_bound, 1'b1, svc_total_q <= ble_pkg::COUNT_W'(MAX_SERVICES), "service count beyond table depth")
	`BLE_ASSERT_NOW(a_err_single, res.valid && (res.error != ble_pkg::ERR_NONE), res.item_last && (res.out_byte == '0), "error result is not a lone zero byte")
	`BLE_ASSERT_NOW(a_new_slot, res.valid && res.service_new, res.service_count == ble_pkg::COUNT_W'(res.slot) + 1'b1, "new service not in the last slot")
	`BLE_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "request taken while the previous one is in progress")

endmodule

@@ hw/rtl/ble_svc_table.sv @@
module ble_svc_table #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic                       clk,
	input  ble_pkg::tbl_ctrl_t         ctrl,
	input  logic [IDX_W-1:0]           wr_addr,
	input  logic [ble_pkg::CODE_W-1:0] wr_data,
	input  logic [IDX_W-1:0]           rd_addr,
	input  logic [ble_pkg::CODE_W-1:0] key,
	output logic                       hit
);

	logic [ble_pkg::CODE_W-1:0] mem [DEPTH];
	logic [ble_pkg::CODE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// The single comparator that the search loop reuses for every slot.
	assign hit = (rd_data_q == key);

endmodule

@@ tb/block_list_encoder_tb.sv @@
module block_list_encoder_tb;

	localparam int MAX_SVC = 16;
	// Random requests beside the directed ones, for about 310 in all.
	localparam int unsigned RAND_ITEMS = 289;

	typedef struct {
		bit          start;
		logic [15:0] code;
		logic [2:0]  mode;
		logic [15:0] blk;
		bit          hold;
		int unsigned phase;
	} block_req_t;

	logic clk;
	logic arst_n;

	ble_req_if req();
	ble_res_if res();

	block_list_encoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.res    (res.source)
	);

	block_req_t       pending_reqs[$];
	ble_pkg::result_t expected_bytes[$];
	block_req_t       held;
	int unsigned      cur_phase;
	int unsigned      mismatches;

	// Idle percentages per phase: sender, then receiver.
	int unsigned send_idle[3] = '{33, 50, 0};
	int unsigned recv_idle[3] = '{50, 33, 0};

	// Mirror of the encoder state.
	logic [15:0] svc_tab[MAX_SVC];
	logic [4:0]  svc_cnt;
	logic [8:0]  list_len;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.start_list = 1'b0;
		req.service_code = '0;
		req.access_mode = '0;
		req.block_number = '0;
		res.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic add_expected(input logic [7:0] b, input bit last, input logic [3:0] s,
			input bit fresh, input ble_pkg::err_t err);
		ble_pkg::result_t e;
		e.out_byte = b;
		e.item_last = last;
		e.slot = s;
		e.service_new = fresh;
		e.service_count = svc_cnt;
		e.list_length = list_len;
		e.error = err;
		expected_bytes.push_back(e);
	endtask

	task automatic encode_block(input block_req_t r);
		logic [3:0] s;
		logic [7:0] hdr;
		bit         found;
		bit         fresh;
		s = '0;
		found = 1'b0;
		fresh = 1'b0;
		if (r.start) begin
			svc_cnt = '0;
			list_len = '0;
		end
		if (list_len >= ble_pkg::MaxListBytes) begin
			add_expected(8'h00, 1'b1, 4'h0, 1'b0, ble_pkg::ERR_LIST_FULL);
			return;
		end
		for (int i = 0; i < svc_cnt; i++) begin
			if (!found && svc_tab[i] == r.code) begin
				found = 1'b1;
				s = i[3:0];
			end
		end
		if (!found) begin
			if (svc_cnt >= MAX_SVC) begin
				add_expected(8'h00, 1'b1, 4'h0, 1'b0, ble_pkg::ERR_TABLE_FULL);
				return;
			end
			s = svc_cnt[3:0];
			svc_tab[s] = r.code;
			svc_cnt++;
			fresh = 1'b1;
		end
		hdr = {1'b0, r.mode, s};
		if (r.blk > 16'd255) begin
			list_len++;
			add_expected(hdr, 1'b0, s, fresh, ble_pkg::ERR_NONE);
			list_len++;
			add_expected(r.blk[7:0], 1'b0, s, fresh, ble_pkg::ERR_NONE);
			list_len++;
			add_expected(r.blk[15:8], 1'b1, s, fresh, ble_pkg::ERR_NONE);
		end else begin
			list_len++;
			add_expected(hdr | 8'h80, 1'b0, s, fresh, ble_pkg::ERR_NONE);
			list_len++;
			add_expected(r.blk[7:0], 1'b1, s, fresh, ble_pkg::ERR_NONE);
		end
	endtask

	task automatic queue_req(input bit start, input logic [15:0] code, input logic [2:0] mode,
			input logic [15:0] blk);
		block_req_t r;
		r.start = start;
		r.code = code;
		r.mode = mode;
		r.blk = blk;
		r.hold = 1'b0;
		r.phase = 0;
		pending_reqs.push_back(r);
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	initial begin
		logic [15:0] pool[20];
		int unsigned made;
		int unsigned list_idx;
		int unsigned n;
		int unsigned npool;
		int unsigned big_pct;
		logic [15:0] code;
		logic [15:0] blk;

		// Directed part: extremes, lookup hits, element sizes, a full table and a restart.
		queue_req(1'b1, 16'h0000, 3'd0, 16'd0);
		queue_req(1'b0, 16'hFFFF, 3'd7, 16'hFFFF);
		queue_req(1'b0, 16'h0000, 3'd5, 16'd255);
		queue_req(1'b0, 16'hFFFF, 3'd2, 16'd256);
		for (int i = 2; i < 16; i++)
			queue_req(1'b0, 16'(16'h1000 + i), 3'(i % 8),
				(i % 2) ? 16'(16'h8000 | i) : 16'(i * 37));
		queue_req(1'b0, 16'hBEEF, 3'd3, 16'd1);
		queue_req(1'b0, 16'hFFFF, 3'd7, 16'h00FF);
		queue_req(1'b1, 16'hBEEF, 3'd1, 16'h0100);

		// Random lists, each opened by a start; a few are long enough to fill the list.
		made = 0;
		list_idx = 0;
		while (made < RAND_ITEMS) begin
			if (list_idx == 1 || $urandom_range(0, 9) == 0) begin
				n = $urandom_range(90, 110);
				big_pct = 80;
			end else begin
				n = $urandom_range(1, 24);
				big_pct = 50;
			end
			if (n > RAND_ITEMS - made)
				n = RAND_ITEMS - made;
			npool = $urandom_range(1, 20);
			for (int i = 0; i < 20; i++)
				pool[i] = ($urandom_range(0, 9) == 0) ? 16'hFFFF
					: 16'($urandom_range(0, 65535));
			for (int k = 0; k < n; k++) begin
				code = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
					: pool[$urandom_range(0, npool - 1)];
				blk = ($urandom_range(0, 99) < big_pct) ? 16'($urandom_range(256, 65535))
					: 16'($urandom_range(0, 255));
				queue_req((k == 0) || ($urandom_range(0, 39) == 0), code,
					3'($urandom_range(0, 7)), blk);
				made++;
			end
			list_idx++;
		end

		foreach (pending_reqs[i]) begin
			pending_reqs[i].phase = (i * 3) / pending_reqs.size();
			pending_reqs[i].hold = (i > 0 && pending_reqs[i].phase != pending_reqs[i - 1].phase)
				|| $urandom_range(0, 49) == 0;
		end
	end

	// Sender: takes requests from the queue and predicts each one as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			bit presenting;
			presenting = req.valid;
			if (presenting && req.ready) begin
				encode_block(held);
				presenting = 1'b0;
			end
			if (!presenting && pending_reqs.size() != 0) begin
				// A held request waits until every expected byte has come back.
				if (!(pending_reqs[0].hold && expected_bytes.size() != 0)
						&& $urandom_range(0, 99) >= send_idle[pending_reqs[0].phase]) begin
					held = pending_reqs.pop_front();
					cur_phase = held.phase;
					presenting = 1'b1;
				end
			end
			req.valid <= presenting;
			req.start_list <= held.start;
			req.service_code <= held.code;
			req.access_mode <= held.mode;
			req.block_number <= held.blk;
		end
	end

	// Receiver: compares each accepted byte with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			ble_pkg::result_t e;
			if (res.valid && res.ready) begin
				if (expected_bytes.size() == 0) begin
					$error("result with nothing expected: out_byte %0d", res.out_byte);
					mismatches++;
				end else begin
					e = expected_bytes.pop_front();
					check_field("out_byte", e.out_byte, res.out_byte);
					check_field("item_last", e.item_last, res.item_last);
					check_field("slot", e.slot, res.slot);
					check_field("service_new", e.service_new, res.service_new);
					check_field("service_count", e.service_count, res.service_count);
					check_field("list_length", e.list_length, res.list_length);
					check_field("error", e.error, res.error);
				end
			end
			res.ready <= ($urandom_range(0, 99) >= recv_idle[cur_phase]);
		end
	end

	initial begin
		svc_cnt = '0;
		list_len = '0;
		mismatches = 0;
		cur_phase = 0;
		held = '{default: '0};
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || req.valid || expected_bytes.size() != 0);
		repeat (100) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			$error("%0d expected bytes never arrived", expected_bytes.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ble_pkg.sv
hw/rtl/ble_req_if.sv
hw/rtl/ble_res_if.sv
hw/rtl/ble_svc_table.sv
hw/rtl/block_list_encoder.sv
tb/block_list_encoder_tb.sv
